>>> sv/imhq_pkg.sv
// package for the indexed min-heap queue: command and status codes, widths
// no dependencies
package imhq_pkg;
   localparam int DefCapacity = 64;
   localparam int DefKeyBits  = 32;
   localparam int Handles     = 64;
   localparam int IdBits      = 6;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_EXTRACT = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_ABSENT  = 3'd3;
   localparam logic [2:0] ST_PRESENT = 3'd4;
endpackage

>>> sv/indexed_min_heap_queue_unit.sv
// indexed min-heap queue: one command per transfer, one result per command
// a rejected or unused command is answered from the check state; an insert sifts up
// (parent read, compare per level) and writes; an update sifts up then down and an
// extract sifts the last entry down (child read, left then right compare per level)
// throughput: one command at a time, a new request is taken after the result transfer
// reset: synchronous, clears presence bits, entry count, control and result valid
module indexed_min_heap_queue_unit import imhq_pkg::*; #(
   parameter int CAPACITY = DefCapacity,
   parameter int KEY_BITS = DefKeyBits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [IdBits-1:0] req_item_id,
   input  logic [31:0]       req_key,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_min_key,
   output logic [IdBits-1:0] rsp_min_id,
   output logic [6:0]        rsp_count
);
   localparam int SB = $clog2(CAPACITY);
   localparam int CB = $clog2(CAPACITY + 1);
   localparam int WB = SB + 2;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK  = 4'd1;
   localparam logic [3:0] S_EXR  = 4'd2;
   localparam logic [3:0] S_EXT  = 4'd3;
   localparam logic [3:0] S_UPR  = 4'd4;
   localparam logic [3:0] S_UPC  = 4'd5;
   localparam logic [3:0] S_DNR  = 4'd6;
   localparam logic [3:0] S_DNL  = 4'd7;
   localparam logic [3:0] S_DNC  = 4'd8;
   localparam logic [3:0] S_WR   = 4'd9;

   logic [KEY_BITS-1:0] keys_mem [CAPACITY];
   logic [IdBits-1:0]   hnd_mem  [CAPACITY];
   logic [SB-1:0]       pos_mem  [Handles];
   logic [Handles-1:0]  present_ff;
   logic [CB-1:0]       count_ff;

   logic [3:0]          state_ff;
   logic [1:0]          cmd_ff;
   logic [IdBits-1:0]   id_ff;
   logic [KEY_BITS-1:0] key_ff;     // key of the entry being sifted
   logic [IdBits-1:0]   hnd_ff;     // handle of the entry being sifted
   logic [SB-1:0]       cur_ff;     // hole the entry currently sits in
   logic [SB-1:0]       pos_rd_ff;
   logic                go_down_ff; // after sift-up, continue down
   logic [KEY_BITS-1:0] rdk_ff;
   logic [IdBits-1:0]   rdh_ff;
   logic [KEY_BITS-1:0] rdk2_ff;
   logic [IdBits-1:0]   rdh2_ff;
   logic [KEY_BITS-1:0] bkey_ff;    // smaller of entry and left child
   logic                bchild_ff;  // left child won
   logic                rsp_valid_ff;
   logic [2:0]          status_ff;
   logic [31:0]         mkey_ff;
   logic [IdBits-1:0]   mid_ff;

   // memory port controls
   logic                rd_en;
   logic [SB-1:0]       rd_a, rd_b;
   logic                wr_en;
   logic [SB-1:0]       wr_a;
   logic [KEY_BITS-1:0] wr_k;
   logic [IdBits-1:0]   wr_h;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdk_ff  <= keys_mem[rd_a];
         rdh_ff  <= hnd_mem[rd_a];
         rdk2_ff <= keys_mem[rd_b];
         rdh2_ff <= hnd_mem[rd_b];
      end
      if (wr_en) begin
         keys_mem[wr_a] <= wr_k;
         hnd_mem[wr_a]  <= wr_h;
         pos_mem[wr_h]  <= wr_a;
      end
      if (req_valid && req_ready) pos_rd_ff <= pos_mem[req_item_id];
   end

   // shared comparator
   logic [KEY_BITS-1:0] cmp_a, cmp_b;
   logic                cmp_lt;
   assign cmp_lt = cmp_a < cmp_b;

   logic [WB-1:0] lw, rw, cw;
   assign cw = WB'(cur_ff);
   assign lw = (cw << 1) + WB'(1);
   assign rw = (cw << 1) + WB'(2);
   logic l_in, r_in;
   assign l_in = lw < WB'(count_ff);
   assign r_in = rw < WB'(count_ff);

   logic [SB-1:0] par;
   assign par = SB'((cw - WB'(1)) >> 1);

   logic dn_right;
   assign dn_right = (state_ff == S_DNC) && r_in && cmp_lt;

   always_comb begin
      rd_en = 1'b0; rd_a = cur_ff; rd_b = cur_ff;
      wr_en = 1'b0; wr_a = cur_ff; wr_k = key_ff; wr_h = hnd_ff;
      cmp_a = key_ff; cmp_b = rdk_ff;
      unique case (state_ff)
         S_UPR: begin
            rd_en = 1'b1; rd_a = par;
         end
         S_UPC: begin
            // parent moves down into the hole
            if (cmp_lt) begin
               wr_en = 1'b1; wr_k = rdk_ff; wr_h = rdh_ff;
            end
         end
         S_DNR: begin
            rd_en = l_in; rd_a = SB'(lw); rd_b = SB'(rw);
         end
         S_DNL: begin
            cmp_a = rdk_ff; cmp_b = key_ff;
         end
         S_DNC: begin
            // smaller child moves up into the hole
            cmp_a = rdk2_ff; cmp_b = bkey_ff;
            if (dn_right) begin
               wr_en = 1'b1; wr_k = rdk2_ff; wr_h = rdh2_ff;
            end else if (bchild_ff) begin
               wr_en = 1'b1; wr_k = rdk_ff; wr_h = rdh_ff;
            end
         end
         S_EXR: begin
            rd_en = 1'b1; rd_a = '0; rd_b = SB'(count_ff - CB'(1));
         end
         S_WR: begin
            wr_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         present_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         go_down_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff   <= req_cmd;
                  id_ff    <= req_item_id;
                  key_ff   <= KEY_BITS'(req_key);
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               status_ff <= ST_OK;
               mkey_ff   <= '0;
               mid_ff    <= '0;
               hnd_ff    <= id_ff;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (present_ff[id_ff]) begin
                        status_ff    <= ST_PRESENT;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else if (count_ff == CB'(CAPACITY)) begin
                        status_ff    <= ST_FULL;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        present_ff[id_ff] <= 1'b1;
                        cur_ff     <= SB'(count_ff);
                        count_ff   <= count_ff + CB'(1);
                        go_down_ff <= 1'b0;
                        state_ff   <= (count_ff == '0) ? S_WR : S_UPR;
                     end
                  end
                  CMD_UPDATE: begin
                     if (!present_ff[id_ff]) begin
                        status_ff    <= ST_ABSENT;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        cur_ff     <= pos_rd_ff;
                        go_down_ff <= 1'b1;
                        state_ff   <= (pos_rd_ff == '0) ? S_DNR : S_UPR;
                     end
                  end
                  CMD_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_ff    <= ST_EMPTY;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        state_ff <= S_EXR;
                     end
                  end
                  default: begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               endcase
            end
            S_EXR: state_ff <= S_EXT;
            S_EXT: begin
               // root leaves, last entry is carried down from the root
               mkey_ff <= 32'(rdk_ff);
               mid_ff  <= rdh_ff;
               present_ff[rdh_ff] <= 1'b0;
               count_ff <= count_ff - CB'(1);
               key_ff   <= rdk2_ff;
               hnd_ff   <= rdh2_ff;
               cur_ff   <= '0;
               if (count_ff == CB'(1)) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_DNR;
               end
            end
            S_UPR: state_ff <= S_UPC;
            S_UPC: begin
               if (cmp_lt) begin
                  cur_ff <= par;
                  if (par == '0) state_ff <= go_down_ff ? S_DNR : S_WR;
                  else state_ff <= S_UPR;
               end else begin
                  state_ff <= go_down_ff ? S_DNR : S_WR;
               end
            end
            S_DNR: state_ff <= l_in ? S_DNL : S_WR;
            S_DNL: begin
               if (cmp_lt) begin
                  bkey_ff   <= rdk_ff;
                  bchild_ff <= 1'b1;
               end else begin
                  bkey_ff   <= key_ff;
                  bchild_ff <= 1'b0;
               end
               state_ff <= S_DNC;
            end
            S_DNC: begin
               if (dn_right) begin
                  cur_ff   <= SB'(rw);
                  state_ff <= S_DNR;
               end else if (bchild_ff) begin
                  cur_ff   <= SB'(lw);
                  state_ff <= S_DNR;
               end else begin
                  state_ff <= S_WR;
               end
            end
            S_WR: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_min_key = mkey_ff;
   assign rsp_min_id  = mid_ff;
   assign rsp_count   = 7'(count_ff);
endmodule

>>> sv/imhq_checker.sv
// port-level checks for the indexed min-heap queue
// depends on imhq_pkg and the top level ports
module imhq_checker import imhq_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_status,
   input logic [31:0]       rsp_min_key,
   input logic [IdBits-1:0] rsp_min_id,
   input logic [6:0]        rsp_count
);
   // no new transfer while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   // a taken request gets no result in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   // failed results carry zero payload
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_min_key == '0 && rsp_min_id == '0))
      else $error("payload on failed command");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= 7'd64) else $error("count out of range");
   // a stalled result holds steady
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_min_key) && $stable(rsp_min_id) && $stable(rsp_count)))
      else $error("result changed while stalled");
endmodule

bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (.*);
